@@ rtl/rwsp_pkg.sv @@
// ----------------------------------------------------------------------------
// RIFF/WAVE stream parser package
// Payload types, result and error codes, and tag constants that are shared by
// the channel interfaces, the parser core and the top level.
// ----------------------------------------------------------------------------
package rwsp_pkg;

   // Four-character tags, as they assemble from little-endian bytes.
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [31:0] FMT_BYTES  = 32'd16;
   localparam logic [31:0] HDR_BYTES  = 32'd8;
   localparam logic [31:0] FORM_BYTES = 32'd4;

   localparam logic [15:0] CHANNELS_MONO   = 16'd1;
   localparam logic [15:0] CHANNELS_STEREO = 16'd2;
   localparam logic [15:0] BITS_8          = 16'd8;
   localparam logic [15:0] BITS_16         = 16'd16;

   // Result kinds.
   localparam logic [1:0] KIND_AUDIO  = 2'd0;
   localparam logic [1:0] KIND_FORMAT = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   // Error codes.
   localparam logic [2:0] ERR_TRUNCATED = 3'd0;
   localparam logic [2:0] ERR_NO_RIFF   = 3'd1;
   localparam logic [2:0] ERR_NO_WAVE   = 3'd2;
   localparam logic [2:0] ERR_FMT_SHORT = 3'd3;
   localparam logic [2:0] ERR_NO_FMT    = 3'd4;
   localparam logic [2:0] ERR_CHANNELS  = 3'd5;
   localparam logic [2:0] ERR_BITS      = 3'd6;
   localparam logic [2:0] ERR_NO_DATA   = 3'd7;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       stream_end;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  audio_byte;
      logic        last_audio;
      logic [2:0]  error_code;
      logic [15:0] format_tag;
      logic [1:0]  channel_count;
      logic [4:0]  sample_bits;
      logic [31:0] sample_rate;
      logic [31:0] avg_byte_rate;
      logic [15:0] block_align;
   } rsp_payload_type;

   // Places a byte into a little-endian word; position zero starts a new word.
   function automatic logic [31:0] put_byte(input logic [31:0] word,
                                            input logic [1:0]  pos,
                                            input logic [7:0]  value);
      logic [31:0] result;
      result = word | ({24'd0, value} << {pos, 3'b000});
      if (pos == 2'd0) begin
         result = {24'd0, value};
      end
      return result;
   endfunction

endpackage

@@ rtl/rwsp_if.sv @@
// ----------------------------------------------------------------------------
// RIFF/WAVE stream parser channels
// Valid/ready channels for input bytes and for parser results.
// ----------------------------------------------------------------------------
interface rwsp_req_if import rwsp_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rwsp_rsp_if import rwsp_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/rwsp_core.sv @@
// ----------------------------------------------------------------------------
// RIFF/WAVE stream parser core
// Holds the parse state and works out the state update and the result of one
// accepted byte combinationally.
// ----------------------------------------------------------------------------
module rwsp_core import rwsp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  req_payload_type item,
   output rsp_payload_type result,
   output logic            result_valid
);

   typedef enum logic [3:0] {
      PH_RIFF_ID,
      PH_RIFF_SIZE,
      PH_FORM,
      PH_HEADER,
      PH_FMT,
      PH_SKIP,
      PH_DATA,
      PH_DONE,
      PH_ERROR
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [4:0]  field_count_ff, field_count_in;
   logic [31:0] riff_remaining_ff, riff_remaining_in;
   logic [31:0] chunk_tag_ff, chunk_tag_in;
   logic [31:0] chunk_length_ff, chunk_length_in;
   logic [31:0] chunk_remaining_ff, chunk_remaining_in;
   logic [31:0] payload_remaining_ff, payload_remaining_in;
   logic [15:0] held_format_tag_ff, held_format_tag_in;
   logic [15:0] held_channels_ff, held_channels_in;
   logic [31:0] held_rate_ff, held_rate_in;
   logic [31:0] held_byte_rate_ff, held_byte_rate_in;
   logic [15:0] held_align_ff, held_align_in;
   logic [15:0] held_bits_ff, held_bits_in;
   logic        fmt_seen_ff, fmt_seen_in;
   logic        data_seen_ff, data_seen_in;

   logic [4:0]  k;
   logic [7:0]  b;
   logic [31:0] tag_new;
   logic [31:0] hdr_length;
   logic [31:0] body_left;
   logic [31:0] aligned;
   logic        fits;
   logic [31:0] eff;
   logic [31:0] pay;
   logic [31:0] pay_clamped;
   logic [31:0] form_left;
   logic [31:0] chunk_dec;

   always_comb begin
      k          = field_count_ff;
      b          = item.in_byte;
      tag_new    = put_byte(chunk_tag_ff, k[1:0], b);
      hdr_length = put_byte(chunk_length_ff, k[1:0], b);
      body_left  = riff_remaining_ff - HDR_BYTES;
      aligned    = hdr_length + {31'd0, hdr_length[0] && (hdr_length != '1)};
      // The body count stays even, so comparing the raw length is enough.
      fits       = hdr_length < body_left;
      eff        = fits ? aligned : body_left;
      pay        = (held_bits_ff == BITS_16) ? {hdr_length[31:1], 1'b0} : hdr_length;
      pay_clamped = (pay < body_left) ? pay : body_left;
      form_left  = riff_remaining_ff - FORM_BYTES;
      chunk_dec  = (chunk_remaining_ff != 32'd0) ? chunk_remaining_ff - 32'd1
                                                 : chunk_remaining_ff;
   end

   always_comb begin
      phase_in             = phase_ff;
      field_count_in       = field_count_ff;
      riff_remaining_in    = riff_remaining_ff;
      chunk_tag_in         = chunk_tag_ff;
      chunk_length_in      = chunk_length_ff;
      chunk_remaining_in   = chunk_remaining_ff;
      payload_remaining_in = payload_remaining_ff;
      held_format_tag_in   = held_format_tag_ff;
      held_channels_in     = held_channels_ff;
      held_rate_in         = held_rate_ff;
      held_byte_rate_in    = held_byte_rate_ff;
      held_align_in        = held_align_ff;
      held_bits_in         = held_bits_ff;
      fmt_seen_in          = fmt_seen_ff;
      data_seen_in         = data_seen_ff;
      result               = '0;
      result_valid         = 1'b0;

      if (phase_ff == PH_DONE || phase_ff == PH_ERROR) begin
         // Finished: every later item is swallowed.
      end else if (phase_ff == PH_HEADER && k == 5'd0 && riff_remaining_ff == 32'd0) begin
         result_valid = 1'b1;
         if (data_seen_ff) begin
            phase_in    = PH_DONE;
            result.kind = KIND_DONE;
         end else begin
            phase_in          = PH_ERROR;
            result.kind       = KIND_ERROR;
            result.error_code = ERR_NO_DATA;
         end
      end else if ((phase_ff == PH_HEADER && k == 5'd0 && riff_remaining_ff < HDR_BYTES)
                   || item.stream_end) begin
         phase_in          = PH_ERROR;
         result_valid      = 1'b1;
         result.kind       = KIND_ERROR;
         result.error_code = ERR_TRUNCATED;
      end else begin
         case (phase_ff)
            PH_RIFF_ID: begin
               chunk_tag_in   = tag_new;
               field_count_in = k + 5'd1;
               if (k == 5'd3) begin
                  field_count_in = 5'd0;
                  if (tag_new != TAG_RIFF) begin
                     phase_in          = PH_ERROR;
                     result_valid      = 1'b1;
                     result.kind       = KIND_ERROR;
                     result.error_code = ERR_NO_RIFF;
                  end else begin
                     phase_in = PH_RIFF_SIZE;
                  end
               end
            end
            PH_RIFF_SIZE: begin
               riff_remaining_in = put_byte(riff_remaining_ff, k[1:0], b);
               field_count_in    = k + 5'd1;
               if (k == 5'd3) begin
                  field_count_in = 5'd0;
                  phase_in       = PH_FORM;
               end
            end
            PH_FORM: begin
               chunk_tag_in   = tag_new;
               field_count_in = k + 5'd1;
               if (k == 5'd3) begin
                  field_count_in = 5'd0;
                  if (tag_new != TAG_WAVE) begin
                     phase_in          = PH_ERROR;
                     result_valid      = 1'b1;
                     result.kind       = KIND_ERROR;
                     result.error_code = ERR_NO_WAVE;
                  end else begin
                     // Drop the form tag from the body and round up to even.
                     riff_remaining_in = (riff_remaining_ff < FORM_BYTES) ? 32'd0
                                         : form_left + {31'd0, form_left[0]};
                     phase_in = PH_HEADER;
                  end
               end
            end
            PH_HEADER: begin
               if (k < 5'd4) begin
                  chunk_tag_in = tag_new;
               end else begin
                  chunk_length_in = hdr_length;
               end
               field_count_in = k + 5'd1;
               if (k == 5'd7) begin
                  riff_remaining_in  = body_left - eff;
                  chunk_remaining_in = eff;
                  field_count_in     = 5'd0;
                  if (chunk_tag_ff == TAG_FMT) begin
                     if (hdr_length < FMT_BYTES) begin
                        phase_in          = PH_ERROR;
                        result_valid      = 1'b1;
                        result.kind       = KIND_ERROR;
                        result.error_code = ERR_FMT_SHORT;
                     end else if (eff < FMT_BYTES) begin
                        phase_in          = PH_ERROR;
                        result_valid      = 1'b1;
                        result.kind       = KIND_ERROR;
                        result.error_code = ERR_TRUNCATED;
                     end else begin
                        phase_in = PH_FMT;
                     end
                  end else if (chunk_tag_ff == TAG_DATA) begin
                     result_valid = 1'b1;
                     if (!fmt_seen_ff) begin
                        phase_in          = PH_ERROR;
                        result.kind       = KIND_ERROR;
                        result.error_code = ERR_NO_FMT;
                     end else if (held_channels_ff != CHANNELS_MONO
                                  && held_channels_ff != CHANNELS_STEREO) begin
                        phase_in          = PH_ERROR;
                        result.kind       = KIND_ERROR;
                        result.error_code = ERR_CHANNELS;
                     end else if (held_bits_ff != BITS_8 && held_bits_ff != BITS_16) begin
                        phase_in          = PH_ERROR;
                        result.kind       = KIND_ERROR;
                        result.error_code = ERR_BITS;
                     end else begin
                        payload_remaining_in = pay_clamped;
                        data_seen_in         = 1'b1;
                        phase_in             = (eff == 32'd0) ? PH_HEADER : PH_DATA;
                        result.kind          = KIND_FORMAT;
                        result.format_tag    = held_format_tag_ff;
                        result.channel_count = held_channels_ff[1:0];
                        result.sample_bits   = held_bits_ff[4:0];
                        result.sample_rate   = held_rate_ff;
                        result.avg_byte_rate = held_byte_rate_ff;
                        result.block_align   = held_align_ff;
                     end
                  end else begin
                     phase_in = (eff == 32'd0) ? PH_HEADER : PH_SKIP;
                  end
               end
            end
            PH_FMT: begin
               if (k < 5'd2) begin
                  held_format_tag_in = 16'(put_byte({16'd0, held_format_tag_ff}, k[1:0], b));
               end else if (k < 5'd4) begin
                  held_channels_in = 16'(put_byte({16'd0, held_channels_ff}, {1'b0, k[0]}, b));
               end else if (k < 5'd8) begin
                  held_rate_in = put_byte(held_rate_ff, k[1:0], b);
               end else if (k < 5'd12) begin
                  held_byte_rate_in = put_byte(held_byte_rate_ff, k[1:0], b);
               end else if (k < 5'd14) begin
                  held_align_in = 16'(put_byte({16'd0, held_align_ff}, {1'b0, k[0]}, b));
               end else begin
                  held_bits_in = 16'(put_byte({16'd0, held_bits_ff}, {1'b0, k[0]}, b));
               end
               chunk_remaining_in = chunk_remaining_ff - 32'd1;
               field_count_in     = k + 5'd1;
               if (k >= 5'd15) begin
                  // Any fmt bytes past the fixed fields are skipped.
                  fmt_seen_in    = 1'b1;
                  field_count_in = 5'd0;
                  phase_in = (chunk_remaining_ff == 32'd1) ? PH_HEADER : PH_SKIP;
               end
            end
            PH_SKIP: begin
               chunk_remaining_in = chunk_dec;
               field_count_in     = 5'd0;
               if (chunk_dec == 32'd0) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_DATA: begin
               chunk_remaining_in = chunk_dec;
               field_count_in     = 5'd0;
               if (chunk_dec == 32'd0) begin
                  phase_in = PH_HEADER;
               end
               // Pad and odd trailing bytes fall through without a result.
               if (payload_remaining_ff != 32'd0) begin
                  result_valid         = 1'b1;
                  result.kind          = KIND_AUDIO;
                  result.audio_byte    = b;
                  result.last_audio    = (payload_remaining_ff == 32'd1);
                  payload_remaining_in = payload_remaining_ff - 32'd1;
               end
            end
            default: begin
               phase_in          = PH_ERROR;
               result_valid      = 1'b1;
               result.kind       = KIND_ERROR;
               result.error_code = ERR_TRUNCATED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff             <= PH_RIFF_ID;
         field_count_ff       <= '0;
         riff_remaining_ff    <= '0;
         chunk_tag_ff         <= '0;
         chunk_length_ff      <= '0;
         chunk_remaining_ff   <= '0;
         payload_remaining_ff <= '0;
         held_format_tag_ff   <= '0;
         held_channels_ff     <= '0;
         held_rate_ff         <= '0;
         held_byte_rate_ff    <= '0;
         held_align_ff        <= '0;
         held_bits_ff         <= '0;
         fmt_seen_ff          <= 1'b0;
         data_seen_ff         <= 1'b0;
      end else if (accept) begin
         phase_ff             <= phase_in;
         field_count_ff       <= field_count_in;
         riff_remaining_ff    <= riff_remaining_in;
         chunk_tag_ff         <= chunk_tag_in;
         chunk_length_ff      <= chunk_length_in;
         chunk_remaining_ff   <= chunk_remaining_in;
         payload_remaining_ff <= payload_remaining_in;
         held_format_tag_ff   <= held_format_tag_in;
         held_channels_ff     <= held_channels_in;
         held_rate_ff         <= held_rate_in;
         held_byte_rate_ff    <= held_byte_rate_in;
         held_align_ff        <= held_align_in;
         held_bits_ff         <= held_bits_in;
         fmt_seen_ff          <= fmt_seen_in;
         data_seen_ff         <= data_seen_in;
      end
   end

endmodule

@@ rtl/riff_wave_stream_parser.sv @@
// ----------------------------------------------------------------------------
// RIFF/WAVE stream parser
// Parses a WAV byte stream: checks the RIFF/WAVE header, walks the chunks,
// captures the fmt fields, reports the format and passes data bytes through.
//
//   channel      role    payload
//   req_stream   sink    in_byte, stream_end
//   rsp_stream   source  kind, audio_byte, last_audio, error_code, format fields
//
// One byte is accepted per cycle; its result, if any, shows on rsp_stream in
// the next cycle from the output register. The parse state updates in the
// accepting cycle. Reset clears the parse state and the output valid. Input
// stalls whenever a result waits in the output register and rsp_stream is not
// ready, even when the next item would give no result.
// ----------------------------------------------------------------------------
module riff_wave_stream_parser import rwsp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rwsp_req_if.sink   req_stream,
   rwsp_rsp_if.source rsp_stream
);

   logic            accept;
   rsp_payload_type result;
   logic            result_valid;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff;

   assign req_stream.ready = !rsp_valid_ff || rsp_stream.ready;
   assign accept           = req_stream.valid && req_stream.ready;

   rwsp_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .item         (req_stream.payload),
      .result       (result),
      .result_valid (result_valid)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = result_valid;
      end else if (rsp_stream.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept && result_valid) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_stream.valid   = rsp_valid_ff;
   assign rsp_stream.payload = rsp_payload_ff;

endmodule

@@ tb/riff_wave_stream_parser_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RIFF/WAVE stream parser testbench
// Streams one long WAV image through the parser: directed chunks first, then
// random fmt, data and foreign chunks, then a randomly chosen way of ending
// the stream. A byte-level parser model in this file predicts every result,
// and each result from the block is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module riff_wave_stream_parser_tb import rwsp_pkg::*; ();

   typedef enum logic [3:0] {
      P_RIFF_ID, P_RIFF_SIZE, P_FORM, P_HEADER, P_FMT, P_SKIP, P_DATA, P_DONE, P_ERROR
   } parse_phase_type;

   logic clock;
   logic reset;

   rwsp_req_if req_chan ();
   rwsp_rsp_if rsp_chan ();

   riff_wave_stream_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_chan),
      .rsp_stream (rsp_chan)
   );

   // Parser model state.
   parse_phase_type ph = P_RIFF_ID;
   logic [4:0]  fcount = '0;
   logic [31:0] riff_left = '0;
   logic [31:0] chunk_tag = '0;
   logic [31:0] chunk_len = '0;
   logic [31:0] chunk_left = '0;
   logic [31:0] pay_left = '0;
   logic [15:0] fmt_tag = '0;
   logic [15:0] fmt_channels = '0;
   logic [31:0] fmt_rate = '0;
   logic [31:0] fmt_byte_rate = '0;
   logic [15:0] fmt_align = '0;
   logic [15:0] fmt_bits = '0;
   logic        fmt_seen = 1'b0;
   logic        data_seen = 1'b0;

   rsp_payload_type awaited[$];
   logic [127:0]    fmt_image;
   int failures = 0;
   int bytes_sent = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;

   function automatic logic [31:0] le_insert(logic [31:0] w, logic [1:0] pos, logic [7:0] b);
      if (pos == 2'd0) return {24'd0, b};
      return w | ({24'd0, b} << (8 * pos));
   endfunction

   function automatic rsp_payload_type stop_with_error(logic [2:0] code);
      rsp_payload_type r = '0;
      r.kind = KIND_ERROR;
      r.error_code = code;
      ph = P_ERROR;
      return r;
   endfunction

   function automatic void next_body();
      if (chunk_left == 0) ph = P_HEADER;
      fcount = '0;
   endfunction

   function automatic bit finish_header(output rsp_payload_type r);
      logic [31:0] aligned;
      logic [31:0] eff;
      logic [31:0] pay;
      r = '0;
      aligned = chunk_len;
      if (aligned[0] && aligned != 32'hFFFF_FFFF) aligned = aligned + 1;
      riff_left = riff_left - HDR_BYTES;
      eff = (aligned < riff_left) ? aligned : riff_left;
      riff_left = riff_left - eff;
      chunk_left = eff;
      fcount = '0;
      if (chunk_tag == TAG_FMT) begin
         if (chunk_len < FMT_BYTES) begin
            r = stop_with_error(ERR_FMT_SHORT);
            return 1;
         end
         if (eff < FMT_BYTES) begin
            r = stop_with_error(ERR_TRUNCATED);
            return 1;
         end
         ph = P_FMT;
         return 0;
      end
      if (chunk_tag == TAG_DATA) begin
         if (!fmt_seen) begin
            r = stop_with_error(ERR_NO_FMT);
            return 1;
         end
         if (fmt_channels != CHANNELS_MONO && fmt_channels != CHANNELS_STEREO) begin
            r = stop_with_error(ERR_CHANNELS);
            return 1;
         end
         if (fmt_bits != BITS_8 && fmt_bits != BITS_16) begin
            r = stop_with_error(ERR_BITS);
            return 1;
         end
         pay = chunk_len;
         if (fmt_bits == BITS_16) pay[0] = 1'b0;
         pay_left = (pay < eff) ? pay : eff;
         data_seen = 1'b1;
         ph = P_DATA;
         next_body();
         r.kind = KIND_FORMAT;
         r.format_tag = fmt_tag;
         r.channel_count = fmt_channels[1:0];
         r.sample_bits = fmt_bits[4:0];
         r.sample_rate = fmt_rate;
         r.avg_byte_rate = fmt_byte_rate;
         r.block_align = fmt_align;
         return 1;
      end
      ph = P_SKIP;
      next_body();
      return 0;
   endfunction

   // Advances the model by one accepted byte; returns 1 when a result is due.
   function automatic bit parse_byte(input logic [7:0] b, input logic e,
                                     output rsp_payload_type r);
      logic [4:0] k;
      r = '0;
      if (ph == P_DONE || ph == P_ERROR) return 0;
      // The verdict is due at a chunk boundary once the body is used up.
      if (ph == P_HEADER && fcount == 0) begin
         if (riff_left == 0) begin
            if (data_seen) begin
               ph = P_DONE;
               r.kind = KIND_DONE;
            end else begin
               r = stop_with_error(ERR_NO_DATA);
            end
            return 1;
         end
         if (riff_left < HDR_BYTES) begin
            r = stop_with_error(ERR_TRUNCATED);
            return 1;
         end
      end
      if (e) begin
         r = stop_with_error(ERR_TRUNCATED);
         return 1;
      end
      k = fcount;
      case (ph)
         P_RIFF_ID: begin
            chunk_tag = le_insert(chunk_tag, k[1:0], b);
            fcount = k + 5'd1;
            if (fcount == 4) begin
               fcount = '0;
               if (chunk_tag != TAG_RIFF) begin
                  r = stop_with_error(ERR_NO_RIFF);
                  return 1;
               end
               ph = P_RIFF_SIZE;
            end
         end
         P_RIFF_SIZE: begin
            riff_left = le_insert(riff_left, k[1:0], b);
            fcount = k + 5'd1;
            if (fcount == 4) begin
               fcount = '0;
               ph = P_FORM;
            end
         end
         P_FORM: begin
            chunk_tag = le_insert(chunk_tag, k[1:0], b);
            fcount = k + 5'd1;
            if (fcount == 4) begin
               fcount = '0;
               if (chunk_tag != TAG_WAVE) begin
                  r = stop_with_error(ERR_NO_WAVE);
                  return 1;
               end
               riff_left = (riff_left < FORM_BYTES) ? '0 : riff_left - FORM_BYTES;
               if (riff_left[0]) riff_left = riff_left + 1;
               ph = P_HEADER;
            end
         end
         P_HEADER: begin
            if (k < 4) chunk_tag = le_insert(chunk_tag, k[1:0], b);
            else chunk_len = le_insert(chunk_len, k[1:0], b);
            fcount = k + 5'd1;
            if (fcount == HDR_BYTES) return finish_header(r);
         end
         P_FMT: begin
            if (k < 2) fmt_tag = 16'(le_insert({16'd0, fmt_tag}, {1'b0, k[0]}, b));
            else if (k < 4)
               fmt_channels = 16'(le_insert({16'd0, fmt_channels}, {1'b0, k[0]}, b));
            else if (k < 8) fmt_rate = le_insert(fmt_rate, k[1:0], b);
            else if (k < 12) fmt_byte_rate = le_insert(fmt_byte_rate, k[1:0], b);
            else if (k < 14) fmt_align = 16'(le_insert({16'd0, fmt_align}, {1'b0, k[0]}, b));
            else fmt_bits = 16'(le_insert({16'd0, fmt_bits}, {1'b0, k[0]}, b));
            chunk_left = chunk_left - 1;
            fcount = k + 5'd1;
            if (fcount >= FMT_BYTES) begin
               fmt_seen = 1'b1;
               ph = P_SKIP;
               next_body();
            end
         end
         P_SKIP: begin
            if (chunk_left != 0) chunk_left = chunk_left - 1;
            next_body();
         end
         P_DATA: begin
            if (chunk_left != 0) chunk_left = chunk_left - 1;
            if (pay_left != 0) begin
               r.kind = KIND_AUDIO;
               r.audio_byte = b;
               r.last_audio = (pay_left == 1);
               pay_left = pay_left - 1;
               next_body();
               return 1;
            end
            next_body();
         end
         default: begin
            r = stop_with_error(ERR_TRUNCATED);
            return 1;
         end
      endcase
      return 0;
   endfunction

   function automatic string describe(rsp_payload_type r);
      return $sformatf("kind=%0d byte=%h last=%b code=%0d tag=%h ch=%0d bits=%0d %s",
                       r.kind, r.audio_byte, r.last_audio, r.error_code, r.format_tag,
                       r.channel_count, r.sample_bits,
                       $sformatf("rate=%h brate=%h align=%h", r.sample_rate,
                                 r.avg_byte_rate, r.block_align));
   endfunction

   task automatic report_failure(input string text);
      failures++;
      if (failures <= 10) $display("%s", text);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic e);
      rsp_payload_type predicted;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.payload <= {b, e};
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
      if (parse_byte(b, e, predicted)) awaited.push_back(predicted);
   endtask

   task automatic send_header(input logic [31:0] tag, input logic [31:0] len);
      for (int i = 0; i < 4; i++) send_byte(tag[8*i +: 8], 1'b0);
      for (int i = 0; i < 4; i++) send_byte(len[8*i +: 8], 1'b0);
   endtask

   // Sends exactly the body bytes the parser will claim, so clamped and padded
   // chunks stay aligned with the stream.
   task automatic send_chunk(input logic [31:0] tag, input logic [31:0] len);
      int i;
      send_header(tag, len);
      i = 0;
      while (ph == P_FMT || ph == P_SKIP || ph == P_DATA) begin
         send_byte((tag == TAG_FMT && i < 16) ? fmt_image[8*i +: 8]
                                              : 8'($urandom_range(255)),
                   1'b0);
         i++;
      end
   endtask

   task automatic load_format(input logic [15:0] tag, input logic [15:0] ch,
                              input logic [31:0] rate, input logic [31:0] brate,
                              input logic [15:0] align, input logic [15:0] bits);
      fmt_image = {bits, align, brate, rate, ch, tag};
   endtask

   function automatic logic [31:0] noise_tag();
      logic [31:0] t;
      if ($urandom_range(1)) t = $urandom;
      else t = ($urandom_range(1) ? TAG_FMT : TAG_DATA) ^ (32'd1 << $urandom_range(31));
      if (t == TAG_FMT || t == TAG_DATA) t[31] = ~t[31];
      return t;
   endfunction

   // Skips an unknown chunk sized so that the given number of body bytes remains.
   task automatic fill_to(input logic [31:0] target);
      send_chunk(noise_tag(), riff_left - HDR_BYTES - target);
   endtask

   task automatic test_file_header();
      logic [31:0] riff_size;
      riff_size = 664 + $urandom_range(0, 81);
      send_header(TAG_RIFF, riff_size);
      for (int i = 0; i < 4; i++) send_byte(TAG_WAVE[8*i +: 8], 1'b0);
   endtask

   task automatic test_format_extremes();
      load_format(16'hFFFF, CHANNELS_STEREO, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, BITS_16);
      send_chunk(TAG_FMT, 18);
   endtask

   task automatic test_padded_payloads();
      // With 16-bit samples an odd byte and the pad byte are both skipped.
      send_chunk(TAG_DATA, 5);
      send_chunk(TAG_DATA, 0);
      send_chunk(TAG_DATA, 1);
      load_format(16'h0000, CHANNELS_MONO, 32'd0, 32'hFFFF_FFFF, 16'h0000, BITS_8);
      send_chunk(TAG_FMT, 16);
      send_chunk(TAG_DATA, 3);
   endtask

   task automatic test_unknown_chunks();
      send_chunk(TAG_DATA ^ 32'h0100_0000, 3);
      send_chunk(noise_tag(), 0);
   endtask

   task automatic test_output_backpressure();
      hold_left = 90;
      send_chunk(TAG_DATA, 48);
   endtask

   task automatic load_random_format(input bit sound);
      logic [15:0] ch;
      logic [15:0] bits;
      if (sound) begin
         ch = $urandom_range(1) ? CHANNELS_STEREO : CHANNELS_MONO;
         bits = $urandom_range(1) ? BITS_16 : BITS_8;
      end else begin
         ch = 16'($urandom);
         bits = 16'($urandom);
      end
      load_format(16'($urandom), ch, $urandom, $urandom, 16'($urandom), bits);
   endtask

   task automatic test_random_chunks();
      int start;
      int quarter;
      int pick;
      start = bytes_sent;
      while (riff_left >= 128) begin
         quarter = (bytes_sent - start) / 90;
         case (quarter)
            0: set_idling(0, 0);
            1: set_idling(78, 0);
            2: set_idling(0, 78);
            default: set_idling(32, 32);
         endcase
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_chunk(TAG_DATA, ($urandom_range(9) == 0) ? $urandom_range(1)
                                                          : $urandom_range(2, 24));
         end else if (pick < 75) begin
            // A format that would be rejected is always replaced before any data.
            if ($urandom_range(3) == 0) begin
               load_random_format(1'b0);
               send_chunk(TAG_FMT, $urandom_range(16, 22));
            end
            load_random_format(1'b1);
            send_chunk(TAG_FMT, $urandom_range(16, 22));
         end else begin
            send_chunk(noise_tag(), $urandom_range(0, 20));
         end
      end
   endtask

   task automatic test_stream_ending();
      logic [31:0] over;
      logic [15:0] ch;
      logic [15:0] bits;
      case ($urandom_range(0, 7))
         0: begin
            send_chunk(noise_tag(), $urandom_range(1) ? riff_left - HDR_BYTES : 32'hFFFF_FFFF);
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
         end
         1: begin
            // The data chunk claims more than the body holds and is cut short.
            over = riff_left - HDR_BYTES + $urandom_range(1, 30);
            if ($urandom_range(1)) over = 32'hFFFF_FFFF - $urandom_range(1);
            send_chunk(TAG_DATA, over);
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
         end
         2: begin
            fill_to(2 * $urandom_range(1, 3));
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
         end
         3: begin
            send_header(TAG_DATA, $urandom_range(10, 24));
            repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(255)), 1'b0);
            send_byte(8'($urandom_range(255)), 1'b1);
         end
         4: send_header(TAG_FMT, $urandom_range(0, 15));
         5: begin
            fill_to(HDR_BYTES + 2 * $urandom_range(0, 7));
            send_header(TAG_FMT, $urandom_range(16, 40));
         end
         6: begin
            do ch = 16'($urandom); while (ch == CHANNELS_MONO || ch == CHANNELS_STEREO);
            load_format(16'($urandom), ch, $urandom, $urandom, 16'($urandom), BITS_16);
            send_chunk(TAG_FMT, 16);
            send_header(TAG_DATA, $urandom_range(0, 20));
         end
         default: begin
            do bits = 16'($urandom); while (bits == BITS_8 || bits == BITS_16);
            load_format(16'($urandom), CHANNELS_MONO, $urandom, $urandom, 16'($urandom),
                        bits);
            send_chunk(TAG_FMT, 16);
            send_header(TAG_DATA, $urandom_range(0, 20));
         end
      endcase
   endtask

   task automatic test_after_verdict();
      repeat (4) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Some tests failed");
      $finish;
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      rsp_payload_type got;
      rsp_payload_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (awaited.size() == 0) begin
            report_failure({"Unexpected result: ", describe(got)});
         end else begin
            want = awaited.pop_front();
            if (got.kind !== want.kind || got.audio_byte !== want.audio_byte ||
                got.last_audio !== want.last_audio || got.error_code !== want.error_code ||
                got.format_tag !== want.format_tag ||
                got.channel_count !== want.channel_count ||
                got.sample_bits !== want.sample_bits ||
                got.sample_rate !== want.sample_rate ||
                got.avg_byte_rate !== want.avg_byte_rate ||
                got.block_align !== want.block_align) begin
               report_failure({"Mismatch: expected ", describe(want),
                               "\n          actual   ", describe(got)});
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_file_header();
      test_format_extremes();
      test_padded_payloads();
      test_unknown_chunks();
      test_output_backpressure();
      test_random_chunks();
      test_stream_ending();
      test_after_verdict();

      @(negedge clock);
      req_chan.valid <= 1'b0;
      set_idling(0, 0);
      while (awaited.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
